// ===== rtl/core/ppu_pkg.sv =====
`default_nettype none

package ppu_pkg;

   typedef enum logic [3:0] {
      KIND_STATIC        = 4'd0,
      KIND_GRAV          = 4'd1,
      KIND_BLOB          = 4'd2,
      KIND_BLOB2         = 4'd3,
      KIND_SMOKE         = 4'd4,
      KIND_SMOKECLOUD    = 4'd5,
      KIND_BLOODCLOUD    = 4'd6,
      KIND_FADESPARK     = 4'd7,
      KIND_FADESPARK2    = 4'd8,
      KIND_FALLFADESPARK = 4'd9
   } kind_type;

   typedef enum logic {
      CSR_FRAME_TIME   = 1'b0,
      CSR_CURRENT_TIME = 1'b1
   } csr_index_type;

   // One particle record as it enters the block.
   typedef struct packed {
      logic [3:0]       kind;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [15:0]      size;
      logic [15:0]      opacity;
      logic [31:0]      expiry;
   } rec_type;

   // Per-kind work decided in the multiply stage and applied in the final stage.
   typedef struct packed {
      logic        alive;
      logic        grow_xyz;
      logic        damp_xy;
      logic        fades;
      logic [25:0] grav_sub;
      logic [13:0] size_add;
      logic [16:0] op_sub;
   } ctl_type;

   localparam logic signed [35:0] SAT_MAX = 36'sh07FFFFFFF;
   localparam logic signed [35:0] SAT_MIN = -36'sh080000000;

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'h7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppu_mul.sv =====
`default_nettype none

module ppu_mul
   import ppu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire rec_type          in_rec,
   input  wire logic [15:0]      frame_time,
   input  wire logic [31:0]      current_time,
   output logic                  out_valid,
   output rec_type               out_rec,
   output ctl_type               out_ctl,
   output logic [2:0][47:0]      out_prod
);

   logic            valid_ff;
   rec_type         rec_ff;
   ctl_type         ctl_ff, ctl_in;
   logic [2:0][47:0] prod_ff, prod_in;
   logic [31:0]     t32;
   logic [31:0]     t_x6, t_x60, t_x4, t_x40, t_x800;

   always_comb begin
      t32    = 32'(frame_time);
      t_x6   = t32 * 32'd6;
      t_x60  = t32 * 32'd60;
      t_x4   = t32 << 2;
      t_x40  = t32 * 32'd40;
      t_x800 = t32 * 32'd800;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = 48'($signed(in_rec.vel[i]) * $signed({1'b0, frame_time}));
      end
   end

   always_comb begin
      ctl_in          = '0;
      ctl_in.alive    = in_rec.expiry > current_time;
      case (kind_type'(in_rec.kind))
         KIND_GRAV: begin
            ctl_in.grav_sub = t_x40[25:0];
         end
         KIND_BLOB: begin
            ctl_in.grow_xyz = 1'b1;
            ctl_in.grav_sub = t_x40[25:0];
         end
         KIND_BLOB2: begin
            ctl_in.damp_xy  = 1'b1;
            ctl_in.grav_sub = t_x40[25:0];
         end
         KIND_SMOKE: begin
            ctl_in.size_add = 14'(t_x6[31:8]);
            ctl_in.op_sub   = 17'(frame_time[15:1]);
            ctl_in.fades    = 1'b1;
         end
         KIND_SMOKECLOUD: begin
            ctl_in.size_add = t_x60[21:8];
            ctl_in.op_sub   = 17'(frame_time[15:1]);
            ctl_in.fades    = 1'b1;
         end
         KIND_BLOODCLOUD: begin
            ctl_in.size_add = 14'(t_x4[31:8]);
            ctl_in.op_sub   = 17'(frame_time[15:2]);
            ctl_in.grav_sub = t_x40[25:0];
            ctl_in.fades    = 1'b1;
         end
         KIND_FADESPARK: begin
            ctl_in.op_sub   = 17'(frame_time);
            ctl_in.grav_sub = t_x40[25:0];
            ctl_in.fades    = 1'b1;
         end
         KIND_FADESPARK2: begin
            ctl_in.op_sub   = {frame_time, 1'b0};
            ctl_in.grav_sub = t_x40[25:0];
            ctl_in.fades    = 1'b1;
         end
         KIND_FALLFADESPARK: begin
            ctl_in.op_sub   = 17'(frame_time);
            ctl_in.grav_sub = t_x800[25:0];
            ctl_in.fades    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= in_rec;
      ctl_ff  <= ctl_in;
      prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;
   assign out_ctl   = ctl_ff;
   assign out_prod  = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ppu_finish.sv =====
`default_nettype none

module ppu_finish
   import ppu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire rec_type          in_rec,
   input  wire ctl_type          in_ctl,
   input  wire logic [2:0][47:0] in_prod,
   output logic                  out_valid,
   output logic                  out_alive,
   output logic [2:0][31:0]      out_pos,
   output logic [2:0][31:0]      out_vel,
   output logic [15:0]           out_size,
   output logic [15:0]           out_opacity,
   output logic [31:0]           out_expiry
);

   logic             valid_ff;
   logic             alive_ff;
   logic [2:0][31:0] pos_ff, pos_in;
   logic [2:0][31:0] vel_ff, vel_in;
   logic [15:0]      size_ff, size_in;
   logic [15:0]      opacity_ff, opacity_in;
   logic [31:0]      expiry_ff, expiry_in;

   logic signed [35:0] pos_sum;
   logic signed [35:0] vel_sum;
   logic signed [35:0] delta;
   logic [16:0]        size_sum;
   logic signed [17:0] op_diff;

   always_comb begin
      pos_in     = in_rec.pos;
      vel_in     = in_rec.vel;
      size_in    = in_rec.size;
      opacity_in = in_rec.opacity;
      expiry_in  = in_rec.expiry;
      pos_sum    = '0;
      vel_sum    = '0;
      delta      = '0;
      size_sum   = '0;
      op_diff    = '0;
      if (in_ctl.alive) begin
         for (int i = 0; i < 3; i++) begin
            // The upper product bits are the floor of vel * t / 2^16 (or 4x that).
            pos_sum = 36'($signed(in_rec.pos[i])) + 36'($signed(in_prod[i][47:16]));
            pos_in[i] = sat32(pos_sum);
            delta = 36'($signed(in_prod[i][47:14]));
            vel_sum = 36'($signed(in_rec.vel[i]));
            if (in_ctl.grow_xyz) begin
               vel_sum = vel_sum + delta;
            end else if (in_ctl.damp_xy && i != 2) begin
               vel_sum = vel_sum - delta;
            end
            if (i == 2) begin
               vel_sum = vel_sum - 36'(in_ctl.grav_sub);
            end
            vel_in[i] = sat32(vel_sum);
         end
         size_sum = 17'(in_rec.size) + 17'(in_ctl.size_add);
         size_in  = size_sum[16] ? 16'hFFFF : size_sum[15:0];
         op_diff  = $signed(18'(in_rec.opacity)) - $signed(18'(in_ctl.op_sub));
         opacity_in = op_diff[17] ? 16'd0 : op_diff[15:0];
         if (in_ctl.fades && opacity_in[15:8] == 8'd0) begin
            expiry_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      alive_ff   <= in_ctl.alive;
      pos_ff     <= pos_in;
      vel_ff     <= vel_in;
      size_ff    <= size_in;
      opacity_ff <= opacity_in;
      expiry_ff  <= expiry_in;
   end

   assign out_valid   = valid_ff;
   assign out_alive   = alive_ff;
   assign out_pos     = pos_ff;
   assign out_vel     = vel_ff;
   assign out_size    = size_ff;
   assign out_opacity = opacity_ff;
   assign out_expiry  = expiry_ff;

endmodule

`default_nettype wire

// ===== rtl/core/particle_physics_update.sv =====
// Channel   Ports                         Transfer
// request   start, busy, req_*            start high and busy low at a clock edge
// response  rsp_valid, rsp_*              rsp_valid high for one cycle, always taken
// csr       csr_write_en, csr_index,      csr_write_en high at a clock edge
//           csr_wdata
//
// A request is taken in every cycle that busy is low; its response passes through
// the input register, the velocity-times-frame-time multiplier register and the
// saturating result register, in that order.
// Synchronous reset clears all valid flags; busy is high only during reset.
// The response side has no stall: each response stands for one cycle.
`default_nettype none

module particle_physics_update
   import ppu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_particle_kind,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_vel_x,
   input  wire logic [31:0] req_vel_y,
   input  wire logic [31:0] req_vel_z,
   input  wire logic [15:0] req_size_in,
   input  wire logic [15:0] req_opacity_in,
   input  wire logic [31:0] req_expiry_in,
   output logic             rsp_valid,
   output logic             rsp_alive,
   output logic [31:0]      rsp_new_pos_x,
   output logic [31:0]      rsp_new_pos_y,
   output logic [31:0]      rsp_new_pos_z,
   output logic [31:0]      rsp_new_vel_x,
   output logic [31:0]      rsp_new_vel_y,
   output logic [31:0]      rsp_new_vel_z,
   output logic [15:0]      rsp_size_out,
   output logic [15:0]      rsp_opacity_out,
   output logic [31:0]      rsp_expiry_out,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic [15:0]      frame_time_ff;
   logic [31:0]      current_time_ff;
   logic             req_valid_ff;
   rec_type          req_rec_ff, req_rec_in;
   logic             accept;

   logic             mul_valid;
   rec_type          mul_rec;
   ctl_type          mul_ctl;
   logic [2:0][47:0] mul_prod;

   logic [2:0][31:0] fin_pos;
   logic [2:0][31:0] fin_vel;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff   <= '0;
         current_time_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_TIME:   frame_time_ff   <= csr_wdata[15:0];
            CSR_CURRENT_TIME: current_time_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_rec_in.kind    = req_particle_kind;
      req_rec_in.pos     = {req_pos_z, req_pos_y, req_pos_x};
      req_rec_in.vel     = {req_vel_z, req_vel_y, req_vel_x};
      req_rec_in.size    = req_size_in;
      req_rec_in.opacity = req_opacity_in;
      req_rec_in.expiry  = req_expiry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      req_rec_ff <= req_rec_in;
   end

   ppu_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid_ff),
      .in_rec       (req_rec_ff),
      .frame_time   (frame_time_ff),
      .current_time (current_time_ff),
      .out_valid    (mul_valid),
      .out_rec      (mul_rec),
      .out_ctl      (mul_ctl),
      .out_prod     (mul_prod)
   );

   ppu_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mul_valid),
      .in_rec      (mul_rec),
      .in_ctl      (mul_ctl),
      .in_prod     (mul_prod),
      .out_valid   (rsp_valid),
      .out_alive   (rsp_alive),
      .out_pos     (fin_pos),
      .out_vel     (fin_vel),
      .out_size    (rsp_size_out),
      .out_opacity (rsp_opacity_out),
      .out_expiry  (rsp_expiry_out)
   );

   assign rsp_new_pos_x = fin_pos[0];
   assign rsp_new_pos_y = fin_pos[1];
   assign rsp_new_pos_z = fin_pos[2];
   assign rsp_new_vel_x = fin_vel[0];
   assign rsp_new_vel_y = fin_vel[1];
   assign rsp_new_vel_z = fin_vel[2];

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ppu_pkg::*;

   localparam logic [3:0] KIND_UNUSED_FIRST = 4'd10;
   localparam logic [3:0] KIND_UNUSED_LAST  = 4'd15;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic             alive;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [15:0]      size;
      logic [15:0]      opacity;
      logic [31:0]      expiry;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_particle_kind = '0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic [31:0] req_vel_x = '0;
   logic [31:0] req_vel_y = '0;
   logic [31:0] req_vel_z = '0;
   logic [15:0] req_size_in = '0;
   logic [15:0] req_opacity_in = '0;
   logic [31:0] req_expiry_in = '0;
   logic        rsp_valid;
   logic        rsp_alive;
   logic [31:0] rsp_new_pos_x;
   logic [31:0] rsp_new_pos_y;
   logic [31:0] rsp_new_pos_z;
   logic [31:0] rsp_new_vel_x;
   logic [31:0] rsp_new_vel_y;
   logic [31:0] rsp_new_vel_z;
   logic [15:0] rsp_size_out;
   logic [15:0] rsp_opacity_out;
   logic [31:0] rsp_expiry_out;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_FRAME_TIME;
   logic [31:0] csr_wdata = '0;

   // Register copies kept by the predictor.
   logic [15:0] frame_len = '0;
   logic [31:0] now_time = '0;

   rec_type          particle_backlog [$];
   frame_result_type expected_updates [$];
   rec_type          next_particle;
   logic             req_taken = 1'b0;
   logic             dense_phase = 1'b0;
   int               gap_left = 0;
   int               issued_count = 0;
   int               checked_count = 0;
   int               mismatch_count = 0;
   int               idle_cycles = 0;

   particle_physics_update dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_particle_kind (req_particle_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_vel_z       (req_vel_z),
      .req_size_in     (req_size_in),
      .req_opacity_in  (req_opacity_in),
      .req_expiry_in   (req_expiry_in),
      .rsp_valid       (rsp_valid),
      .rsp_alive       (rsp_alive),
      .rsp_new_pos_x   (rsp_new_pos_x),
      .rsp_new_pos_y   (rsp_new_pos_y),
      .rsp_new_pos_z   (rsp_new_pos_z),
      .rsp_new_vel_x   (rsp_new_vel_x),
      .rsp_new_vel_y   (rsp_new_vel_y),
      .rsp_new_vel_z   (rsp_new_vel_z),
      .rsp_size_out    (rsp_size_out),
      .rsp_opacity_out (rsp_opacity_out),
      .rsp_expiry_out  (rsp_expiry_out),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // One frame of motion and fading for a single particle record.
   function automatic frame_result_type advance_particle(rec_type p);
      frame_result_type r;
      longint        t;
      longint        vel [3];
      longint        dv [3];
      longint        vz_drop;
      longint        size_add;
      longint        op_sub;
      longint        size_sum;
      longint        op_left;
      logic          fades;
      int            i;
      r.alive = 1'b0;
      r.pos = p.pos;
      r.vel = p.vel;
      r.size = p.size;
      r.opacity = p.opacity;
      r.expiry = p.expiry;
      if (p.expiry <= now_time) begin
         return r;
      end
      r.alive = 1'b1;
      t = longint'(frame_len);
      vz_drop = 0;
      size_add = 0;
      op_sub = 0;
      fades = 1'b0;
      for (i = 0; i < 3; i++) begin
         vel[i] = longint'(signed'(p.vel[i]));
         dv[i] = 0;
         // Position moves with the velocity from before this frame.
         r.pos[i] = clamp32(longint'(signed'(p.pos[i])) + ((vel[i] * t) >>> 16));
      end
      case (p.kind)
         KIND_GRAV: begin
            vz_drop = 40 * t;
         end
         KIND_BLOB: begin
            for (i = 0; i < 3; i++) begin
               dv[i] = (vel[i] * 4 * t) >>> 16;
            end
            vz_drop = 40 * t;
         end
         KIND_BLOB2: begin
            for (i = 0; i < 2; i++) begin
               dv[i] = -((vel[i] * 4 * t) >>> 16);
            end
            vz_drop = 40 * t;
         end
         KIND_SMOKE: begin
            size_add = (t * 6) >> 8;
            op_sub = (t * 128) >> 8;
            fades = 1'b1;
         end
         KIND_SMOKECLOUD: begin
            size_add = (t * 60) >> 8;
            op_sub = (t * 128) >> 8;
            fades = 1'b1;
         end
         KIND_BLOODCLOUD: begin
            size_add = (t * 4) >> 8;
            op_sub = (t * 64) >> 8;
            vz_drop = 40 * t;
            fades = 1'b1;
         end
         KIND_FADESPARK: begin
            op_sub = t;
            vz_drop = 40 * t;
            fades = 1'b1;
         end
         KIND_FADESPARK2: begin
            op_sub = 2 * t;
            vz_drop = 40 * t;
            fades = 1'b1;
         end
         KIND_FALLFADESPARK: begin
            op_sub = t;
            vz_drop = 800 * t;
            fades = 1'b1;
         end
         default: begin
         end
      endcase
      for (i = 0; i < 3; i++) begin
         r.vel[i] = clamp32(vel[i] + dv[i] - ((i == 2) ? vz_drop : 0));
      end
      size_sum = longint'(p.size) + size_add;
      op_left = longint'(p.opacity) - op_sub;
      if (size_sum > 65535) begin
         size_sum = 65535;
      end
      if (op_left < 0) begin
         op_left = 0;
      end
      r.size = size_sum[15:0];
      r.opacity = op_left[15:0];
      if (fades && op_left < 256) begin
         r.expiry = '0;
      end
      return r;
   endfunction

   function automatic rec_type make_particle(logic [3:0] kind,
         logic [31:0] px, logic [31:0] py, logic [31:0] pz,
         logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
         logic [15:0] size, logic [15:0] opac, logic [31:0] expiry);
      rec_type p;
      p.kind = kind;
      p.pos = {pz, py, px};
      p.vel = {vz, vy, vx};
      p.size = size;
      p.opacity = opac;
      p.expiry = expiry;
      return p;
   endfunction

   function automatic logic [31:0] any_word();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5, 6, 7, 8, 9, 10, 11: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] any_half();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      case (sel)
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h00FF;
         3: return 16'h0100;
         4: return 16'h0101;
         5: return 16'($urandom_range(16'hFF00, 16'hFFFF));
         6, 7, 8, 9: return 16'($urandom_range(0, 16'h0600));
         default: return 16'($urandom());
      endcase
   endfunction

   // Most records outlive the current time so that the motion paths get exercised.
   function automatic logic [31:0] any_expiry(logic [31:0] now);
      int unsigned sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0: return now;
         1: return (now == 0) ? now : $urandom_range(0, now - 1);
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return (now == 32'hFFFF_FFFF) ? now : $urandom_range(now + 1, 32'hFFFF_FFFF);
      endcase
   endfunction

   function automatic rec_type random_particle(logic [31:0] now);
      rec_type p;
      int      i;
      if ($urandom_range(0, 9) == 0) begin
         p.kind = 4'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      end else begin
         p.kind = 4'($urandom_range(KIND_STATIC, KIND_FALLFADESPARK));
      end
      for (i = 0; i < 3; i++) begin
         p.pos[i] = any_word();
         p.vel[i] = any_word();
      end
      p.size = any_half();
      p.opacity = any_half();
      p.expiry = any_expiry(now);
      return p;
   endfunction

   function automatic int pick_gap();
      int unsigned sel;
      if (dense_phase) begin
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         return 0;
      end else if (sel < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (want !== got) begin
         note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
      end
   endtask

   // Request driver: a record stays on the bus until its transfer completes.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
      end else if (gap_left != 0) begin
         start <= 1'b0;
         gap_left = gap_left - 1;
      end else if (particle_backlog.size() != 0) begin
         next_particle = particle_backlog.pop_front();
         req_particle_kind <= next_particle.kind;
         req_pos_x <= next_particle.pos[0];
         req_pos_y <= next_particle.pos[1];
         req_pos_z <= next_particle.pos[2];
         req_vel_x <= next_particle.vel[0];
         req_vel_y <= next_particle.vel[1];
         req_vel_z <= next_particle.vel[2];
         req_size_in <= next_particle.size;
         req_opacity_in <= next_particle.opacity;
         req_expiry_in <= next_particle.expiry;
         start <= 1'b1;
         gap_left = pick_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predicts on each request transfer and checks each response.
   always @(posedge clock) begin
      rec_type          seen;
      frame_result_type want;
      if (reset) begin
         frame_len = '0;
         now_time = '0;
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            checked_count++;
            if (expected_updates.size() == 0) begin
               note_failure("response arrived with no update pending");
            end else begin
               want = expected_updates.pop_front();
               check_field("alive", want.alive, rsp_alive);
               check_field("new_pos_x", want.pos[0], rsp_new_pos_x);
               check_field("new_pos_y", want.pos[1], rsp_new_pos_y);
               check_field("new_pos_z", want.pos[2], rsp_new_pos_z);
               check_field("new_vel_x", want.vel[0], rsp_new_vel_x);
               check_field("new_vel_y", want.vel[1], rsp_new_vel_y);
               check_field("new_vel_z", want.vel[2], rsp_new_vel_z);
               check_field("size_out", want.size, rsp_size_out);
               check_field("opacity_out", want.opacity, rsp_opacity_out);
               check_field("expiry_out", want.expiry, rsp_expiry_out);
            end
         end
         if (start && !busy) begin
            seen.kind = req_particle_kind;
            seen.pos = {req_pos_z, req_pos_y, req_pos_x};
            seen.vel = {req_vel_z, req_vel_y, req_vel_x};
            seen.size = req_size_in;
            seen.opacity = req_opacity_in;
            seen.expiry = req_expiry_in;
            expected_updates.push_back(advance_particle(seen));
         end
         if (csr_write_en) begin
            if (csr_index == CSR_FRAME_TIME) begin
               frame_len = csr_wdata[15:0];
            end else begin
               now_time = csr_wdata;
            end
         end
         req_taken <= start && !busy;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic queue_particle(input rec_type p);
      particle_backlog.push_back(p);
      issued_count++;
   endtask

   task automatic wait_for_drain();
      while (checked_count < issued_count) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int          phase;
      int          n_random;
      int          k;
      logic [15:0] ft;
      logic [31:0] ct;
      logic [31:0] e;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 8; phase++) begin
         n_random = 250;
         case (phase)
            0: begin ft = 16'd1092; ct = 32'h0001_0000; end
            1: begin ft = 16'd0; ct = 32'h0000_0000; end
            2: begin ft = 16'hFFFF; ct = $urandom(); end
            3: begin ft = 16'd1; ct = 32'hFFFF_FFFF; n_random = 60; end
            4: begin ft = 16'($urandom()); ct = $urandom(); end
            5: begin ft = 16'd546; ct = $urandom_range(0, 32'h7FFF_FFFF); end
            6: begin ft = 16'($urandom()); ct = 32'h0000_0000; end
            default: begin ft = 16'hFFFF; ct = $urandom_range(0, 32'h0001_0000); end
         endcase
         wait_for_drain();
         write_register(CSR_FRAME_TIME, {16'h0000, ft});
         write_register(CSR_CURRENT_TIME, ct);
         dense_phase = (phase == 2 || phase == 5);
         if (phase == 0) begin
            e = 32'h0010_0000;
            for (k = KIND_STATIC; k <= KIND_FALLFADESPARK; k++) begin
               queue_particle(make_particle(4'(k), 32'h0010_0000, 32'hFFE0_0000,
                  32'h0005_8000, 32'h0003_0000, 32'hFFFE_8000, 32'h0002_0000,
                  16'h0200, 16'h0180, e));
            end
            queue_particle(make_particle(KIND_UNUSED_FIRST + 4'd2, 32'h0000_1000,
               32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h0100, 16'h0080, e));
            queue_particle(make_particle(KIND_UNUSED_LAST, 32'h0, 32'h0, 32'h0,
               32'h0004_0000, 32'h0, 32'hFFFC_0000, 16'h0100, 16'h0010, e));
            // Expired records: expiry equal to and below the current time.
            queue_particle(make_particle(KIND_GRAV, 32'h0001_0000, 32'h0, 32'h0,
               32'h0001_0000, 32'h0, 32'h0, 16'h0100, 16'h0100, ct));
            queue_particle(make_particle(KIND_FALLFADESPARK, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 32'h0, 16'h0100, 16'h0000, 32'h0));
            queue_particle(make_particle(KIND_STATIC, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               16'hFFFF, 16'hFFFF, e));
            queue_particle(make_particle(KIND_GRAV, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               16'h0000, 16'h0000, e));
            queue_particle(make_particle(KIND_BLOB, 32'h0, 32'h0, 32'h0,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0100, 16'h0100, e));
            queue_particle(make_particle(KIND_BLOB2, 32'h0, 32'h0, 32'h0,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0100, 16'h0100, e));
            queue_particle(make_particle(KIND_FALLFADESPARK, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 32'h8000_0000, 16'h0100, 16'hFFFF, e));
            queue_particle(make_particle(KIND_SMOKECLOUD, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 32'h0, 16'hFFFF, 16'h0800, e));
            queue_particle(make_particle(KIND_FADESPARK, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 32'h0, 16'h0100, 16'h0100, e));
            queue_particle(make_particle(KIND_SMOKE, 32'h0, 32'h0, 32'h0,
               32'h0, 32'h0, 32'h0, 16'h0100, 16'h0000, e));
            queue_particle(make_particle(KIND_BLOODCLOUD, 32'h0, 32'h0, 32'h0,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0100, 16'h0400,
               32'hFFFF_FFFF));
         end
         if (phase == 1) begin
            // With no frame time a faded record still loses its expiry.
            queue_particle(make_particle(KIND_FADESPARK2, 32'h0001_0000, 32'h0, 32'h0,
               32'h0001_0000, 32'h0, 32'h0, 16'h0100, 16'h0064, 32'h0000_1000));
            queue_particle(make_particle(KIND_BLOB, 32'h0001_0000, 32'h0, 32'h0,
               32'h0001_0000, 32'h0, 32'h0, 16'h0100, 16'h0064, 32'h0000_1000));
         end
         for (k = 0; k < n_random; k++) begin
            queue_particle(random_particle(ct));
         end
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ppu_pkg.sv
rtl/core/ppu_mul.sv
rtl/core/ppu_finish.sv
rtl/core/particle_physics_update.sv
bench/testbench.sv
